@@ design/tlbpt_pkg.sv @@
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_W;
    localparam int FRAME_W     = $clog2(PAGE_COUNT + 1);
    localparam int TLB_DEPTH   = 32;
    localparam int TLB_IDX_W   = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int TLB_FILL_W  = $clog2(TLB_DEPTH + 1);
    localparam int CNT_W       = 32;
    localparam int OUT_BITS    = ADDR_W + 2 + 2 * CNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic               fault;
        logic [FRAME_W-1:0] frame;
    } pg_lookup_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_lookup_t;

endpackage

@@ design/tlbpt_ram.sv @@
`timescale 1ns / 1ps

module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tlbpt_pager.sv @@
`timescale 1ns / 1ps

module tlbpt_pager
    import tlbpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [PAGE_W-1:0] rd_page,
    input  logic              commit,
    input  logic [PAGE_W-1:0] page,
    output pg_lookup_t        lookup
);

    logic [PAGE_COUNT-1:0] pm_valid_reg;
    logic [FRAME_W-1:0]    next_frame_reg;
    logic [FRAME_W-1:0]    next_frame_next;
    logic                  byp_reg;
    logic [FRAME_W-1:0]    byp_frame_reg;
    logic [FRAME_W-1:0]    ram_rdata;
    logic                  fault;
    logic                  wr_en;

    assign fault = !pm_valid_reg[page];
    assign wr_en = commit && fault;

    always_comb
    begin
        next_frame_next = next_frame_reg;
        if (wr_en && (next_frame_reg < FRAME_W'(PAGE_COUNT)))
        begin
            next_frame_next = next_frame_reg + 1'b1;
        end
    end

    tlbpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_frame_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (page),
        .wdata (next_frame_reg),
        .re    (rd_en),
        .raddr (rd_page),
        .rdata (ram_rdata)
    );

    // same-cycle write of the page being read: forward the new frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_valid_reg   <= '0;
            next_frame_reg <= '0;
            byp_reg        <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                pm_valid_reg[page] <= 1'b1;
            end
            next_frame_reg <= next_frame_next;
            if (rd_en)
            begin
                byp_reg <= wr_en && (rd_page == page);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_frame_reg <= next_frame_reg;
        end
    end

    always_comb
    begin
        lookup.fault = fault;
        if (fault)
        begin
            lookup.frame = next_frame_reg;
        end
        else if (byp_reg)
        begin
            lookup.frame = byp_frame_reg;
        end
        else
        begin
            lookup.frame = ram_rdata;
        end
    end

endmodule

@@ design/tlbpt_tlb.sv @@
`timescale 1ns / 1ps

module tlbpt_tlb
    import tlbpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  logic [PAGE_W-1:0]  page,
    input  logic [FRAME_W-1:0] fill_frame,
    output tlb_lookup_t        lookup
);

    logic [TLB_DEPTH-1:0]  valid_reg;
    logic [PAGE_W-1:0]     page_reg  [TLB_DEPTH];
    logic [FRAME_W-1:0]    frame_reg [TLB_DEPTH];
    logic [TLB_FILL_W-1:0] fill_reg;
    logic [TLB_FILL_W-1:0] fill_next;
    logic [TLB_IDX_W-1:0]  oldest_reg;
    logic [TLB_IDX_W-1:0]  oldest_next;
    logic [TLB_DEPTH-1:0]  match;
    logic [TLB_DEPTH-1:0]  first;
    logic [TLB_IDX_W-1:0]  slot;
    logic                  insert;

    always_comb
    begin
        for (int k = 0; k < TLB_DEPTH; k++)
        begin
            match[k] = valid_reg[k] && (page_reg[k] == page);
        end
        first = match & (~match + 1'b1);
        lookup.hit   = |match;
        lookup.frame = '0;
        for (int k = 0; k < TLB_DEPTH; k++)
        begin
            if (first[k])
            begin
                lookup.frame = lookup.frame | frame_reg[k];
            end
        end
    end

    assign insert = commit && !lookup.hit;

    // fill slots in order, then replace the oldest one
    always_comb
    begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (fill_reg < TLB_FILL_W'(TLB_DEPTH))
        begin
            slot = fill_reg[TLB_IDX_W-1:0];
            if (insert)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        else
        begin
            slot = oldest_reg;
            if (insert)
            begin
                oldest_next = (oldest_reg == TLB_IDX_W'(TLB_DEPTH - 1)) ? '0
                                                                        : oldest_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            if (insert)
            begin
                valid_reg[slot] <= 1'b1;
            end
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            page_reg[slot]  <= page;
            frame_reg[slot] <= fill_frame;
        end
    end

endmodule

@@ design/tlb_page_table_translator_core.sv @@
`timescale 1ns / 1ps
// Input stage register, then result register, loaded when the output can take it.
// One transfer per cycle unless the output stalls (combinational TLB, registered RAM read).
// Reset: asynchronous, active low; clears the TLB and page map valid bits, fill and
// FIFO pointers, the free-frame counter and both counters. No clearing pass; the
// block accepts input as soon as reset is released.
module tlb_page_table_translator_core
    import tlbpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ADDR_W-1:0]     s_axis_tdata,  // [15:0] logical_address
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [15:0] phys_addr, [16] tlb_hit,
                                                 // [17] page_fault, [49:18] hit_count,
                                                 // [81:50] access_count, rest zero
);

    logic                     s1_valid_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic                     s1_fire;
    logic                     in_fire;
    logic [PAGE_W-1:0]        s1_page;
    pg_lookup_t               pg;
    tlb_lookup_t              tlb;
    logic [FRAME_W-1:0]       frame;
    logic [CNT_W-1:0]         hit_cnt_reg;
    logic [CNT_W-1:0]         hit_cnt_next;
    logic [CNT_W-1:0]         acc_cnt_reg;
    logic [CNT_W-1:0]         acc_cnt_next;
    logic                     out_valid_reg;
    logic [ADDR_W-1:0]        out_pa_reg;
    logic                     out_hit_reg;
    logic                     out_fault_reg;
    logic [CNT_W-1:0]         out_hit_cnt_reg;
    logic [CNT_W-1:0]         out_acc_cnt_reg;

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s1_page       = s1_addr_reg[ADDR_W-1:OFFSET_BITS];

    tlbpt_pager u_pager (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_page (s_axis_tdata[ADDR_W-1:OFFSET_BITS]),
        .commit  (s1_fire),
        .page    (s1_page),
        .lookup  (pg)
    );

    tlbpt_tlb u_tlb (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (s1_fire),
        .page       (s1_page),
        .fill_frame (pg.frame),
        .lookup     (tlb)
    );

    assign frame = tlb.hit ? tlb.frame : pg.frame;

    always_comb
    begin
        hit_cnt_next = hit_cnt_reg;
        if (tlb.hit && (hit_cnt_reg != '1))
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
        acc_cnt_next = acc_cnt_reg;
        if (acc_cnt_reg != '1)
        begin
            acc_cnt_next = acc_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
                acc_cnt_reg   <= acc_cnt_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= s_axis_tdata;
        end
        if (s1_fire)
        begin
            out_pa_reg      <= {frame[ADDR_W-OFFSET_BITS-1:0],
                                s1_addr_reg[OFFSET_BITS-1:0]};
            out_hit_reg     <= tlb.hit;
            out_fault_reg   <= pg.fault;
            out_hit_cnt_reg <= hit_cnt_next;
            out_acc_cnt_reg <= acc_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_acc_cnt_reg, out_hit_cnt_reg,
                            out_fault_reg, out_hit_reg, out_pa_reg};

`ifndef NO_ASSERTIONS
    a_hit_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_hit_reg && out_fault_reg))
        else $error("TLB hit on an unmapped page");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_hit_reg) |-> (out_hit_cnt_reg != '0))
        else $error("hit reported with zero hit count");

    a_hits_le_access: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_hit_cnt_reg <= out_acc_cnt_reg))
        else $error("hit count exceeds access count");

    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (m_axis_tvalid && (acc_cnt_reg != '0)))
        else $error("result register not loaded after stage transfer");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tlbpt_pkg::*;

    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  accesses;
    } xlate_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ADDR_W-1:0]     s_axis_tdata = '0;  // [15:0] logical_address
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // [15:0] phys_addr, [16] tlb_hit,
                                               // [17] page_fault, [49:18] hit_count,
                                               // [81:50] access_count, rest zero

    tlb_page_table_translator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow page map and TLB
    bit                 page_mapped [PAGE_COUNT];
    logic [FRAME_W-1:0] page_frame  [PAGE_COUNT];
    int                 free_frame = 0;
    bit                 tlb_valid   [TLB_DEPTH];
    int                 tlb_page    [TLB_DEPTH];
    logic [FRAME_W-1:0] tlb_frame   [TLB_DEPTH];
    int                 tlb_fill = 0;
    int                 tlb_oldest = 0;
    logic [CNT_W-1:0]   hit_total = '0;
    logic [CNT_W-1:0]   access_total = '0;

    xlate_t expected_xlations [$];
    int     mismatches = 0;

    // sender burst control
    bit gaps_on = 1'b1;
    int burst_left = 0;

    // receiver control
    bit stall_on = 1'b1;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int run_left = 0;
    bit stalling = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic xlate_t predict_translation(input logic [ADDR_W-1:0] addr);
        int                              page;
        int                              slot;
        logic                            hit;
        logic                            fault;
        logic [FRAME_W-1:0]              frame;
        logic [FRAME_W+OFFSET_BITS-1:0]  wide;
        xlate_t                          r;
        page  = int'(addr >> OFFSET_BITS) % PAGE_COUNT;
        hit   = 1'b0;
        fault = 1'b0;
        frame = '0;
        if (!page_mapped[page])
        begin
            page_mapped[page] = 1'b1;
            page_frame[page]  = FRAME_W'(free_frame);
            if (free_frame < PAGE_COUNT)
                free_frame++;
            fault = 1'b1;
        end
        for (int k = 0; k < TLB_DEPTH; k++)
        begin
            if (!hit && tlb_valid[k] && tlb_page[k] == page)
            begin
                hit   = 1'b1;
                frame = tlb_frame[k];
            end
        end
        if (hit)
        begin
            if (hit_total != '1)
                hit_total++;
        end
        else
        begin
            frame = page_frame[page];
            if (tlb_fill < TLB_DEPTH)
            begin
                slot = tlb_fill;
                tlb_fill++;
            end
            else
            begin
                slot = tlb_oldest;
                tlb_oldest = (tlb_oldest + 1) % TLB_DEPTH;
            end
            tlb_valid[slot] = 1'b1;
            tlb_page[slot]  = page;
            tlb_frame[slot] = frame;
        end
        if (access_total != '1)
            access_total++;
        wide       = {frame, addr[OFFSET_BITS-1:0]};
        r.phys     = wide[ADDR_W-1:0];
        r.hit      = hit;
        r.fault    = fault;
        r.hits     = hit_total;
        r.accesses = access_total;
        return r;
    endfunction

    task automatic send_addr(input logic [ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = gaps_on ? $urandom_range(1, 16) : 1;
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        expected_xlations.push_back(predict_translation(addr));
    endtask

    task automatic check_translation(input logic [OUT_DATA_W-1:0] d);
        xlate_t want;
        xlate_t got;
        got.phys     = d[ADDR_W-1:0];
        got.hit      = d[ADDR_W];
        got.fault    = d[ADDR_W+1];
        got.hits     = d[ADDR_W+2 +: CNT_W];
        got.accesses = d[ADDR_W+2+CNT_W +: CNT_W];
        if (expected_xlations.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected transfer: phys=%h hit=%b fault=%b hits=%0d acc=%0d",
                         got.phys, got.hit, got.fault, got.hits, got.accesses);
            mismatches++;
        end
        else
        begin
            want = expected_xlations.pop_front();
            if (got != want || (d >> OUT_BITS) != 0)
            begin
                if (mismatches < 10)
                    $display({"mismatch: exp phys=%h hit=%b fault=%b hits=%0d acc=%0d",
                              " | act phys=%h hit=%b fault=%b hits=%0d acc=%0d pad=%h"},
                             want.phys, want.hit, want.fault, want.hits, want.accesses,
                             got.phys, got.hit, got.fault, got.hits, got.accesses,
                             d >> OUT_BITS);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_translation(m_axis_tdata);
        if (hold_served != hold_reqs)
        begin
            hold_served = hold_reqs;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!stall_on)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            if (run_left == 0)
            begin
                stalling = !stalling;
                run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            run_left--;
            m_axis_tready <= !stalling;
        end
    end

    task automatic test_directed();
        logic [ADDR_W-1:0] addrs [$];
        addrs = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'hAA55, 16'h55AA,
                  16'h0000, 16'h0180, 16'h7F01, 16'h8000, 16'hFFFF, 16'h00FF,
                  16'h5555, 16'hAAAA};
        foreach (addrs[i])
            send_addr(addrs[i]);
    endtask

    // fill the TLB, wrap the FIFO, then revisit evicted and resident pages
    task automatic test_tlb_eviction();
        for (int p = 0; p < TLB_DEPTH + 8; p++)
            send_addr({8'(p), 8'($urandom_range(0, 255))});
        for (int p = 0; p < 8; p++)
            send_addr({8'(p), 8'($urandom_range(0, 255))});
        for (int p = 8; p < TLB_DEPTH + 8; p++)
            send_addr({8'(p), 8'($urandom_range(0, 255))});
    endtask

    // drifting working sets around the TLB size, with scattered noise
    task automatic test_random_locality(input int n);
        int base;
        int span;
        int pick;
        logic [ADDR_W-1:0] a;
        base = 0;
        span = 8;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                base = $urandom_range(0, PAGE_COUNT - 1);
                pick = $urandom_range(0, 3);
                span = (pick == 0) ? 8 : (pick == 1) ? 24 : (pick == 2) ? 40 : 64;
            end
            if ($urandom_range(0, 99) < 85)
                a = {8'((base + $urandom_range(0, span - 1)) % PAGE_COUNT),
                     8'($urandom_range(0, 255))};
            else
                a = ADDR_W'($urandom_range(0, 65535));
            send_addr(a);
        end
    endtask

    // touch every page so the frame supply runs out
    task automatic test_map_all_pages();
        for (int p = 0; p < PAGE_COUNT; p++)
            send_addr({8'(p), 8'($urandom_range(0, 255))});
    endtask

    task automatic test_backpressure(input int n);
        gaps_on    = 1'b0;
        burst_left = 0;
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < n; i++)
            send_addr({8'($urandom_range(0, 47)), 8'($urandom_range(0, 255))});
        gaps_on = 1'b1;
    endtask

    task automatic test_free_flow(input int n);
        gaps_on    = 1'b0;
        burst_left = 0;
        stall_on  <= 1'b0;
        for (int i = 0; i < n; i++)
            send_addr({8'($urandom_range(0, 40)), 8'($urandom_range(0, 255))});
        stall_on <= 1'b1;
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tlb_eviction();
        test_random_locality(1000);
        test_backpressure(40);
        test_map_all_pages();
        test_free_flow(250);
        test_backpressure(40);
        s_axis_tvalid <= 1'b0;
        while (expected_xlations.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
design/tlbpt_pkg.sv
design/tlbpt_ram.sv
design/tlbpt_pager.sv
design/tlbpt_tlb.sv
design/tlb_page_table_translator_core.sv
tb/tb.sv
